[hdl/bba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int MAX_BLOCKS_DEF = 4096;
	localparam int WORD_W         = 32;
	localparam int WB_W           = 5;
	localparam int CNT_W          = 13;
	localparam int IDX_W          = 12;
	localparam int TDATA_W        = 16;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_ASUM,
		ST_AWORD,
		ST_AUPD,
		ST_FRD,
		ST_FUPD
	} state_t;

endpackage

[hdl/bitmap_block_allocator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top
// First-fit allocator over a used/free bitmap with a two-level full summary.
// ----------------------------------------------------------------------------
// One request is taken at a time. An allocate passes through accept, summary
// read, bitmap word read and update; a free through accept, word and summary
// read, and update. The reads wait while a result is stalled on the output.
// These steps come from the two synchronous memories, each with a registered
// read: the summary memory (one full flag per bitmap word) and the bitmap
// memory (32 blocks per word). A flag per summary word, held in flip-flops,
// points the search to the first group with room. After reset a clearing pass
// zeroes both memories, one bitmap word per cycle, during which no request is
// accepted. The next request is accepted while a result still waits on the
// output register.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_top #(
	parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [bba_pkg::TDATA_W-1:0] s_axis_tdata,  // [11:0] block_index
	input  logic                        s_axis_tuser,  // [0] req_type
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [bba_pkg::TDATA_W-1:0] m_axis_tdata,  // [11:0] granted_block
	output logic                        m_axis_tuser,  // [0] ok
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bba_pkg::CNT_W-1:0]   cfg_data       // block_count
);
	import bba_pkg::*;

	localparam int NWORDS  = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int NGROUPS = (NWORDS + WORD_W - 1) / WORD_W;
	localparam int WA_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int GA_W    = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
	localparam int WN_W    = GA_W + WB_W;
	localparam int FB_W    = WN_W + WB_W;
	localparam int CW      = ((FB_W > CNT_W) ? FB_W : CNT_W) + 1;

	localparam logic [CW-1:0]   MAX_C    = CW'(MAX_BLOCKS);
	localparam logic [WN_W:0]   NWORDS_C = (WN_W + 1)'(NWORDS);
	localparam logic [WA_W-1:0] CLR_LAST = WA_W'(NWORDS - 1);
	localparam logic [WA_W:0]   NGRP_C   = (WA_W + 1)'(NGROUPS);

	logic [WORD_W-1:0] word_mem [NWORDS];
	logic [WORD_W-1:0] sum_mem  [NGROUPS];

	state_t state_q, state_d;

	logic [WA_W-1:0]    clr_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;
	logic [GA_W-1:0]    ga_q;
	logic [WN_W-1:0]    wn_q;
	logic [NGROUPS-1:0] gfull_q;
	logic               out_valid_q;
	logic               out_ok_q;
	logic [IDX_W-1:0]   out_grant_q;

	logic [WORD_W-1:0] word_rd;
	logic [WORD_W-1:0] sum_rd;

	logic              wm_re, wm_we, sm_re, sm_we;
	logic [WA_W-1:0]   wm_raddr, wm_waddr;
	logic [GA_W-1:0]   sm_raddr, sm_waddr;
	logic [WORD_W-1:0] wm_wdata, sm_wdata;
	logic              res_load, res_ok;
	logic [IDX_W-1:0]  res_grant;
	logic              g_set, g_clr;
	logic [GA_W-1:0]   g_idx;

	logic [CW-1:0]     lim;
	logic              slot_busy;
	logic              gany;
	logic [GA_W-1:0]   gsel;
	logic              wfound;
	logic [WB_W-1:0]   wsel;
	logic [WN_W-1:0]   wn;
	logic              wn_ok;
	logic              bfound;
	logic [WB_W-1:0]   bsel;
	logic [FB_W-1:0]   fb;
	logic              grant_ok;
	logic [WORD_W-1:0] new_word, new_sum;
	logic [CW-1:0]     idx_ext;
	logic              free_ok;
	logic [WN_W-1:0]   f_wn;

	assign lim       = (CW'(count_q) > MAX_C) ? MAX_C : CW'(count_q);
	assign slot_busy = out_valid_q && !m_axis_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		gany = 1'b0;
		gsel = '0;
		for (int i = NGROUPS - 1; i >= 0; i--) begin
			if (!gfull_q[i]) begin
				gany = 1'b1;
				gsel = GA_W'(i);
			end
		end
	end

	always_comb begin
		wfound = 1'b0;
		wsel   = '0;
		bfound = 1'b0;
		bsel   = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!sum_rd[i]) begin
				wfound = 1'b1;
				wsel   = WB_W'(i);
			end
			if (!word_rd[i]) begin
				bfound = 1'b1;
				bsel   = WB_W'(i);
			end
		end
	end

	assign wn       = {ga_q, wsel};
	assign wn_ok    = wfound && ({1'b0, wn} < NWORDS_C);
	assign fb       = {wn_q, bsel};
	assign grant_ok = bfound && (CW'(fb) < lim);
	assign idx_ext  = CW'(idx_q);
	assign free_ok  = idx_ext < lim;
	assign f_wn     = idx_ext[FB_W-1:WB_W];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR:   if (clr_q == CLR_LAST) state_d = ST_IDLE;
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = (s_axis_tuser == REQ_FREE) ? ST_FRD : ST_ASUM;
				end
			end
			ST_ASUM:  if (!slot_busy) state_d = gany ? ST_AWORD : ST_IDLE;
			ST_AWORD: state_d = wn_ok ? ST_AUPD : ST_IDLE;
			ST_AUPD:  state_d = ST_IDLE;
			ST_FRD:   if (!slot_busy) state_d = free_ok ? ST_FUPD : ST_IDLE;
			ST_FUPD:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = 1'b0;
		wm_re = 1'b0; wm_raddr = '0;
		wm_we = 1'b0; wm_waddr = '0; wm_wdata = '0;
		sm_re = 1'b0; sm_raddr = '0;
		sm_we = 1'b0; sm_waddr = '0; sm_wdata = '0;
		res_load = 1'b0; res_ok = 1'b0; res_grant = '0;
		g_set = 1'b0; g_clr = 1'b0; g_idx = '0;
		new_word = word_rd | (WORD_W'(1) << bsel);
		new_sum  = sum_rd | (WORD_W'(1) << wn_q[WB_W-1:0]);
		unique case (state_q)
			ST_CLR: begin
				wm_we    = 1'b1;
				wm_waddr = clr_q;
				sm_we    = ((WA_W + 1)'(clr_q) < NGRP_C);
				sm_waddr = GA_W'(clr_q);
			end
			ST_IDLE: s_axis_tready = 1'b1;
			ST_ASUM: begin
				if (!slot_busy) begin
					sm_re    = gany;
					sm_raddr = gsel;
					res_load = !gany;
				end
			end
			ST_AWORD: begin
				wm_re    = wn_ok;
				wm_raddr = wn[WA_W-1:0];
				res_load = !wn_ok;
			end
			ST_AUPD: begin
				res_load  = 1'b1;
				res_ok    = grant_ok;
				res_grant = grant_ok ? IDX_W'(fb) : '0;
				wm_we     = grant_ok;
				wm_waddr  = wn_q[WA_W-1:0];
				wm_wdata  = new_word;
				sm_we     = grant_ok && (&new_word);
				sm_waddr  = ga_q;
				sm_wdata  = new_sum;
				g_set     = grant_ok && (&new_word) && (&new_sum);
				g_idx     = ga_q;
			end
			ST_FRD: begin
				if (!slot_busy) begin
					wm_re    = free_ok;
					wm_raddr = f_wn[WA_W-1:0];
					sm_re    = free_ok;
					sm_raddr = f_wn[WN_W-1:WB_W];
					res_load = !free_ok;
				end
			end
			ST_FUPD: begin
				res_load = 1'b1;
				res_ok   = 1'b1;
				wm_we    = 1'b1;
				wm_waddr = f_wn[WA_W-1:0];
				wm_wdata = word_rd & ~(WORD_W'(1) << idx_q[WB_W-1:0]);
				sm_we    = 1'b1;
				sm_waddr = f_wn[WN_W-1:WB_W];
				sm_wdata = sum_rd & ~(WORD_W'(1) << f_wn[WB_W-1:0]);
				g_clr    = 1'b1;
				g_idx    = f_wn[WN_W-1:WB_W];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wm_we) word_mem[wm_waddr] <= wm_wdata;
		if (wm_re) word_rd <= word_mem[wm_raddr];
	end

	always_ff @(posedge clk) begin
		if (sm_we) sum_mem[sm_waddr] <= sm_wdata;
		if (sm_re) sum_rd <= sum_mem[sm_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			count_q     <= '0;
			gfull_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) clr_q <= clr_q + 1'b1;
			if (cfg_valid) count_q <= cfg_data;
			if (g_set) gfull_q[g_idx] <= 1'b1;
			else if (g_clr) gfull_q[g_idx] <= 1'b0;
			if (res_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) idx_q <= s_axis_tdata[IDX_W-1:0];
		if (state_q == ST_ASUM) ga_q <= gsel;
		if (state_q == ST_AWORD) wn_q <= wn;
		if (res_load) begin
			out_ok_q    <= res_ok;
			out_grant_q <= res_grant;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_ok_q;
	assign m_axis_tdata  = TDATA_W'(out_grant_q);

endmodule

[hdl/bba_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the bitmap block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic [bba_pkg::TDATA_W-1:0] s_axis_tdata,
	input logic                        s_axis_tuser,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [bba_pkg::TDATA_W-1:0] m_axis_tdata,
	input logic                        m_axis_tuser,
	input logic                        cfg_valid,
	input logic                        cfg_ready,
	input logic [bba_pkg::CNT_W-1:0]   cfg_data
);
	import bba_pkg::*;

	logic unused_ok;
	assign unused_ok = ^{s_axis_tdata, s_axis_tuser, cfg_valid, cfg_ready, cfg_data};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("nonzero block on failed request");

	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while busy");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[TDATA_W-1:IDX_W] == '0)
		else $error("result padding not zero");

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (.*);

[tb/bitmap_block_allocator_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top_tb
// Stream testbench for the first-fit bitmap block allocator. A scoreboard
// keeps its own copy of the used/free bitmap and the block count, works out
// the result of each accepted request and checks the results in order.
// Directed requests cover zero count, saturated count, full map, refused and
// repeated frees; random phases follow at several counts, with a pass that
// fills the map past its first summary group. Both stream sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_top_tb;

	import bba_pkg::*;

	localparam int NBLK = MAX_BLOCKS_DEF;

	typedef struct packed {
		logic             ok;
		logic [IDX_W-1:0] block;
	} grant_t;

	class alloc_scoreboard;
		bit               block_used [NBLK];
		logic [CNT_W-1:0] block_count;
		grant_t           grants_due [$];
		int               errors;

		function new();
			foreach (block_used[i])
				block_used[i] = 1'b0;
			block_count = '0;
			errors      = 0;
		endfunction

		function int limit();
			return (block_count > NBLK) ? NBLK : int'(block_count);
		endfunction

		function void note_request(logic req, logic [IDX_W-1:0] idx);
			grant_t g;
			int     lim;
			lim     = limit();
			g.ok    = 1'b0;
			g.block = '0;
			if (req == REQ_ALLOC) begin
				for (int i = 0; i < lim; i++) begin
					if (!block_used[i]) begin
						block_used[i] = 1'b1;
						g.ok          = 1'b1;
						g.block       = i[IDX_W-1:0];
						break;
					end
				end
			end else if (int'(idx) < lim) begin
				block_used[idx] = 1'b0;
				g.ok            = 1'b1;
			end
			grants_due.push_back(g);
		endfunction

		function void check_result(logic ok, logic [IDX_W-1:0] block);
			grant_t e;
			if (grants_due.size() == 0) begin
				errors++;
				$display("%0t: result with no request pending: ok=%0b block=%0d",
					$time, ok, block);
				return;
			end
			e = grants_due.pop_front();
			if (ok !== e.ok) begin
				errors++;
				$display("%0t: ok mismatch: expected %0b, got %0b", $time, e.ok, ok);
			end
			if (block !== e.block) begin
				errors++;
				$display("%0t: granted_block mismatch: expected %0d, got %0d",
					$time, e.block, block);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata;   // [11:0] block_index
	logic               s_axis_tuser;   // [0] req_type
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [TDATA_W-1:0] m_axis_tdata;   // [11:0] granted_block
	logic               m_axis_tuser;   // [0] ok
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CNT_W-1:0]   cfg_data;

	alloc_scoreboard sb;
	bit              src_idle;
	bit              sink_idle;

	bitmap_block_allocator_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// all tasks start and end on a falling edge
	task automatic send_request(input logic req, input logic [IDX_W-1:0] idx);
		int g;
		g = src_idle ? gap_len() : 0;
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= {{(TDATA_W-IDX_W){1'b0}}, idx};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(req, idx);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.grants_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_block_count(input logic [CNT_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.block_count = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_mix(input logic [CNT_W-1:0] count, input int n);
		int               alloc_pct;
		int               lim;
		logic             req;
		logic [IDX_W-1:0] idx;
		write_block_count(count);
		src_idle  = ($urandom_range(0, 3) != 0);
		sink_idle = ($urandom_range(0, 3) != 0);
		alloc_pct = $urandom_range(30, 80);
		lim       = sb.limit();
		repeat (n) begin
			req = ($urandom_range(0, 99) < alloc_pct) ? REQ_ALLOC : REQ_FREE;
			if (lim > 0 && $urandom_range(0, 4) != 0)
				idx = IDX_W'($urandom_range(0, lim - 1));
			else
				idx = IDX_W'($urandom());
			send_request(req, idx);
		end
	endtask

	// result side: random stalls
	initial begin
		int g;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			g = sink_idle ? gap_len() : 0;
			if (g > 0) begin
				m_axis_tready <= 1'b0;
				repeat (g) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tuser, m_axis_tdata[IDX_W-1:0]);
	end

	initial begin
		#20_000_000;
		$display("** bitmap_block_allocator_top: FAILED **");
		$finish;
	end

	initial begin
		sb            = new();
		src_idle      = 1'b1;
		sink_idle     = 1'b1;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// count zero after reset: nothing can be granted or freed
		send_request(REQ_ALLOC, '0);
		send_request(REQ_FREE, '0);
		send_request(REQ_FREE, '1);

		// count above map size saturates
		write_block_count('1);
		send_request(REQ_ALLOC, '1);
		send_request(REQ_ALLOC, '0);
		send_request(REQ_ALLOC, '0);
		send_request(REQ_FREE, 12'd1);
		send_request(REQ_ALLOC, '0);
		send_request(REQ_FREE, '1);
		send_request(REQ_FREE, '0);
		send_request(REQ_FREE, '0);
		send_request(REQ_ALLOC, '0);

		// single block: full map and out-of-range free
		write_block_count(13'd1);
		send_request(REQ_ALLOC, '0);
		send_request(REQ_FREE, 12'd1);
		send_request(REQ_FREE, '0);
		send_request(REQ_ALLOC, '0);
		send_request(REQ_ALLOC, '1);

		run_mix(13'd4096, 40);
		run_mix(13'd64, 40);
		run_mix(13'd33, 40);
		run_mix(13'd1, 20);
		run_mix(13'd0, 20);
		run_mix(13'd32, 40);
		run_mix(13'd31, 40);
		run_mix(13'd8191, 40);
		run_mix(13'd4095, 40);
		run_mix(CNT_W'($urandom_range(0, 8191)), 40);
		run_mix(CNT_W'($urandom_range(1, 300)), 40);

		// fill the first summary group and one word more, then churn near full
		write_block_count(13'd1056);
		src_idle  = ($urandom_range(0, 1) != 0);
		sink_idle = ($urandom_range(0, 1) != 0);
		repeat (1056 + 4)
			send_request(REQ_ALLOC, IDX_W'($urandom()));
		run_mix(13'd1056, 60);
		run_mix(13'd8191, 40);

		wait_idle();
		if (sb.errors == 0 && sb.grants_due.size() == 0)
			$display("** bitmap_block_allocator_top: PASSED **");
		else
			$display("** bitmap_block_allocator_top: FAILED **");
		$finish;
	end

endmodule
